/* src/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types and constants for the line follower PID drive
// Holds the arithmetic widths, the register map with its reset values and
// the configuration bundle that the register file hands to the datapath.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    // Arithmetic sizing.
    localparam int SUM_WIDTH      = 24;  // error integral, signed
    localparam int GAIN_FRAC_BITS = 16;  // fraction bits of the Q2.x gains
    localparam int GAIN_W         = GAIN_FRAC_BITS + 2;
    localparam int LEVEL_W        = 7;   // sample, set point, red band
    localparam int ERR_W          = LEVEL_W + 1;
    localparam int DERIV_W        = ERR_W + 1;
    localparam int SPEED_W        = 8;
    localparam int CORR_W         = 16;
    localparam int DRV_SUM_W      = CORR_W + 1;

    // Product and accumulator widths (signed, gain is zero-extended by one bit).
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_WIDTH;
    localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
    localparam int ACC_W    = PROD_I_W + 2;

    // Drive limits.
    localparam logic signed [DRV_SUM_W-1:0] DRIVE_MAX = DRV_SUM_W'(100);
    localparam logic signed [DRV_SUM_W-1:0] DRIVE_MIN = -DRV_SUM_W'(100);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_MARK_LOW     = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_MARK_HIGH    = CFG_IDX_W'(6);

    localparam logic [LEVEL_W-1:0] RST_TARGET_LEVEL = LEVEL_W'(40);
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN    = GAIN_W'(29491);
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN   = GAIN_W'(52);
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN   = GAIN_W'(58982);
    localparam logic [SPEED_W-1:0] RST_BASE_SPEED   = SPEED_W'(30);
    localparam logic [LEVEL_W-1:0] RST_MARK_LOW     = LEVEL_W'(65);
    localparam logic [LEVEL_W-1:0] RST_MARK_HIGH    = LEVEL_W'(75);

    typedef struct packed {
        logic [LEVEL_W-1:0] target_level;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [SPEED_W-1:0] base_speed;
        logic [LEVEL_W-1:0] mark_low;
        logic [LEVEL_W-1:0] mark_high;
    } t_cfg;

endpackage

/* src/lfpd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lfpd_cfg_regs: configuration register file
// Seven loop settings written through a valid/ready port; writes to an
// index past the last register are dropped.
// ----------------------------------------------------------------------------
module lfpd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output lfpd_pkg::t_cfg                   o_cfg
);

    lfpd_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_level <= lfpd_pkg::RST_TARGET_LEVEL;
            r_cfg.prop_gain    <= lfpd_pkg::RST_PROP_GAIN;
            r_cfg.integ_gain   <= lfpd_pkg::RST_INTEG_GAIN;
            r_cfg.deriv_gain   <= lfpd_pkg::RST_DERIV_GAIN;
            r_cfg.base_speed   <= lfpd_pkg::RST_BASE_SPEED;
            r_cfg.mark_low     <= lfpd_pkg::RST_MARK_LOW;
            r_cfg.mark_high    <= lfpd_pkg::RST_MARK_HIGH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lfpd_pkg::REG_TARGET_LEVEL: begin
                    r_cfg.target_level <= i_cfg_data[lfpd_pkg::LEVEL_W-1:0];
                end
                lfpd_pkg::REG_PROP_GAIN: begin
                    r_cfg.prop_gain <= i_cfg_data[lfpd_pkg::GAIN_W-1:0];
                end
                lfpd_pkg::REG_INTEG_GAIN: begin
                    r_cfg.integ_gain <= i_cfg_data[lfpd_pkg::GAIN_W-1:0];
                end
                lfpd_pkg::REG_DERIV_GAIN: begin
                    r_cfg.deriv_gain <= i_cfg_data[lfpd_pkg::GAIN_W-1:0];
                end
                lfpd_pkg::REG_BASE_SPEED: begin
                    r_cfg.base_speed <= i_cfg_data[lfpd_pkg::SPEED_W-1:0];
                end
                lfpd_pkg::REG_MARK_LOW: begin
                    r_cfg.mark_low <= i_cfg_data[lfpd_pkg::LEVEL_W-1:0];
                end
                lfpd_pkg::REG_MARK_HIGH: begin
                    r_cfg.mark_high <= i_cfg_data[lfpd_pkg::LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* src/line_follow_pid_drive.sv */
// ----------------------------------------------------------------------------
// line_follow_pid_drive: PID steering for a line follower on two motors
// Turns each reflectance sample into a saturated correction, a left and a
// right duty cycle, and a red-mark flag.
// ----------------------------------------------------------------------------
// The block accepts one sample word per clock cycle while o_in_stall is low
// and returns one result word per sample, in order. Each result word is
// held on the outputs, with o_out_valid high, until an edge at which the
// output side is not stalled takes it. The sample enters the input
// register at the accepting edge and then passes four more stages: an error
// stage that also updates the error integral and the remembered last error,
// a stage of three registered multipliers, a stage that sums the products,
// floors them by the gain fraction and saturates to 16 bits, and the output
// register that forms the two saturated drive values. Each stage holds its
// word when the stage after it is full and stalled, so a waiting result does
// not stop new samples from entering until the whole pipeline is full. The
// integral and the last error are updated exactly once per sample, when it
// leaves the input register. Settings are written through their own port,
// always ready, and take effect for samples that arrive after the write;
// they should only be changed while no sample is in flight.
// ----------------------------------------------------------------------------
module line_follow_pid_drive (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Sample channel.
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [lfpd_pkg::LEVEL_W-1:0]           i_reflect_sample,
    // Result channel.
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [lfpd_pkg::SPEED_W-1:0]    o_left_drive,
    output logic signed [lfpd_pkg::SPEED_W-1:0]    o_right_drive,
    output logic signed [lfpd_pkg::CORR_W-1:0]     o_correction,
    output logic                                   o_red_mark,
    // Configuration write channel.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int SW  = lfpd_pkg::SUM_WIDTH;
    localparam int AW  = lfpd_pkg::ACC_W;
    localparam int FB  = lfpd_pkg::GAIN_FRAC_BITS;
    localparam int CW  = lfpd_pkg::CORR_W;
    localparam int DW  = lfpd_pkg::DRV_SUM_W;

    lfpd_pkg::t_cfg w_cfg;

    lfpd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // ------------------------------------------------------------------
    // Stage occupancy and advance. A stage loads when it is empty or when
    // the stage after it is loading too.
    // ------------------------------------------------------------------
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic w_en0, w_en1, w_en2, w_en3, w_en4;

    assign w_en4 = !r_v4 || !i_out_stall;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en0 = !r_v0 || w_en1;

    assign o_in_stall  = !w_en0;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en0) begin
                r_v0 <= i_in_valid;
            end
            if (w_en1) begin
                r_v1 <= r_v0;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register.
    // ------------------------------------------------------------------
    logic [lfpd_pkg::LEVEL_W-1:0] r_s0_sample;

    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_s0_sample <= i_reflect_sample;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: error, derivative, saturating integral and red band test.
    // The integral and the last error are loop state and reset to zero.
    // ------------------------------------------------------------------
    logic signed [SW-1:0]                   r_error_sum;
    logic signed [lfpd_pkg::ERR_W-1:0]      r_prev_error;
    logic signed [lfpd_pkg::ERR_W-1:0]      n_err;
    logic signed [lfpd_pkg::DERIV_W-1:0]    n_deriv;
    logic signed [SW:0]                     n_sum_wide;
    logic signed [SW-1:0]                   n_error_sum;
    logic                                   n_red;

    always_comb begin
        // Both levels are at most 127, so the difference fits eight bits.
        n_err = $signed({1'b0, w_cfg.target_level}) - $signed({1'b0, r_s0_sample});
        n_deriv = lfpd_pkg::DERIV_W'(n_err) - lfpd_pkg::DERIV_W'(r_prev_error);
        n_sum_wide = (SW + 1)'(r_error_sum) + (SW + 1)'(n_err);
        if (n_sum_wide[SW] != n_sum_wide[SW-1]) begin
            // Overflow: pin to the extreme on the side of the true sum.
            n_error_sum = {n_sum_wide[SW], {(SW - 1){!n_sum_wide[SW]}}};
        end else begin
            n_error_sum = n_sum_wide[SW-1:0];
        end
        n_red = (r_s0_sample >= w_cfg.mark_low) && (r_s0_sample <= w_cfg.mark_high);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_prev_error <= '0;
        end else if (r_v0 && w_en1) begin
            r_error_sum  <= n_error_sum;
            r_prev_error <= n_err;
        end
    end

    logic signed [lfpd_pkg::ERR_W-1:0]   r_s1_err;
    logic signed [lfpd_pkg::DERIV_W-1:0] r_s1_deriv;
    logic signed [SW-1:0]                r_s1_sum;
    logic                                r_s1_red;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_err   <= n_err;
            r_s1_deriv <= n_deriv;
            r_s1_sum   <= n_error_sum;
            r_s1_red   <= n_red;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three gain products, each into its own register.
    // ------------------------------------------------------------------
    logic signed [lfpd_pkg::GAIN_W:0]     w_kp, w_ki, w_kd;
    logic signed [lfpd_pkg::PROD_P_W-1:0] r_s2_prod_p;
    logic signed [lfpd_pkg::PROD_I_W-1:0] r_s2_prod_i;
    logic signed [lfpd_pkg::PROD_D_W-1:0] r_s2_prod_d;
    logic                                 r_s2_red;

    assign w_kp = $signed({1'b0, w_cfg.prop_gain});
    assign w_ki = $signed({1'b0, w_cfg.integ_gain});
    assign w_kd = $signed({1'b0, w_cfg.deriv_gain});

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_prod_p <= lfpd_pkg::PROD_P_W'(w_kp) * lfpd_pkg::PROD_P_W'(r_s1_err);
            r_s2_prod_i <= lfpd_pkg::PROD_I_W'(w_ki) * lfpd_pkg::PROD_I_W'(r_s1_sum);
            r_s2_prod_d <= lfpd_pkg::PROD_D_W'(w_kd) * lfpd_pkg::PROD_D_W'(r_s1_deriv);
            r_s2_red    <= r_s1_red;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum, floor by the gain fraction, saturate to 16 bits.
    // An arithmetic shift of a two's complement value rounds toward minus
    // infinity, which is the required floor.
    // ------------------------------------------------------------------
    logic signed [AW-1:0]   n_acc;
    logic signed [AW-1:0]   n_shifted;
    logic [AW-CW:0]         n_top;
    logic signed [CW-1:0]   n_corr;

    always_comb begin
        n_acc = AW'(r_s2_prod_p) + AW'(r_s2_prod_i) + AW'(r_s2_prod_d);
        n_shifted = n_acc >>> FB;
        n_top = n_shifted[AW-1:CW-1];
        if ((&n_top) || !(|n_top)) begin
            n_corr = n_shifted[CW-1:0];
        end else begin
            n_corr = {n_shifted[AW-1], {(CW - 1){!n_shifted[AW-1]}}};
        end
    end

    logic signed [CW-1:0] r_s3_corr;
    logic                 r_s3_red;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_corr <= n_corr;
            r_s3_red  <= r_s2_red;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: drive values around the base speed, saturated to +/-100.
    // ------------------------------------------------------------------
    logic signed [DW-1:0]                 n_base;
    logic signed [DW-1:0]                 n_left_wide, n_right_wide;
    logic signed [lfpd_pkg::SPEED_W-1:0]  n_left, n_right;

    always_comb begin
        n_base       = DW'($signed(w_cfg.base_speed));
        n_left_wide  = n_base - DW'(r_s3_corr);
        n_right_wide = n_base + DW'(r_s3_corr);
        if (n_left_wide > lfpd_pkg::DRIVE_MAX) begin
            n_left = lfpd_pkg::DRIVE_MAX[lfpd_pkg::SPEED_W-1:0];
        end else if (n_left_wide < lfpd_pkg::DRIVE_MIN) begin
            n_left = lfpd_pkg::DRIVE_MIN[lfpd_pkg::SPEED_W-1:0];
        end else begin
            n_left = n_left_wide[lfpd_pkg::SPEED_W-1:0];
        end
        if (n_right_wide > lfpd_pkg::DRIVE_MAX) begin
            n_right = lfpd_pkg::DRIVE_MAX[lfpd_pkg::SPEED_W-1:0];
        end else if (n_right_wide < lfpd_pkg::DRIVE_MIN) begin
            n_right = lfpd_pkg::DRIVE_MIN[lfpd_pkg::SPEED_W-1:0];
        end else begin
            n_right = n_right_wide[lfpd_pkg::SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            o_left_drive  <= n_left;
            o_right_drive <= n_right;
            o_correction  <= r_s3_corr;
            o_red_mark    <= r_s3_red;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The input side is only held off while the input register is full.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v0)
        else $error("input stalled with an empty input register");

    // The loop state moves with the word that leaves the input register.
    a_state_follows_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && w_en1) |=> (r_prev_error == r_s1_err) && (r_error_sum == r_s1_sum))
        else $error("loop state out of step with stage one");

    // Both drives always lie in the duty cycle range.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_drive >= -8'sd100) && (o_left_drive <= 8'sd100)
                     && (o_right_drive >= -8'sd100) && (o_right_drive <= 8'sd100))
        else $error("drive value outside -100..100");

    // An empty red band never flags a mark.
    a_empty_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (w_cfg.mark_low > w_cfg.mark_high)) |-> !o_red_mark)
        else $error("red mark raised with an empty band");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the line follower PID drive
// Streams reflectance samples through the steering pipeline under several
// register settings and back-pressure patterns. An independent fixed-point
// model of the steering law predicts every result word, and the words are
// checked in order, field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int HALF_PERIOD   = 2;          // 4 ns clock
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 20;         // well past the five-stage pipeline depth
    localparam int TIMEOUT_NS    = 200_000;

    localparam int LEVEL_W        = lfpd_pkg::LEVEL_W;
    localparam int GAIN_W         = lfpd_pkg::GAIN_W;
    localparam int GAIN_FRAC_BITS = lfpd_pkg::GAIN_FRAC_BITS;
    localparam int SPEED_W        = lfpd_pkg::SPEED_W;
    localparam int CORR_W         = lfpd_pkg::CORR_W;
    localparam int ERR_W          = lfpd_pkg::ERR_W;
    localparam int SUM_WIDTH      = lfpd_pkg::SUM_WIDTH;
    localparam int CFG_IDX_W      = lfpd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = lfpd_pkg::CFG_DATA_W;

    // Index past the register list; the block must drop writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(7);

    localparam longint INTEG_MAX = (longint'(1) << (SUM_WIDTH - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam longint CORR_MAX  = (longint'(1) << (CORR_W - 1)) - 1;
    localparam longint CORR_MIN  = -CORR_MAX - 1;

    // One result word as the block presents it.
    typedef struct packed {
        logic signed [SPEED_W-1:0] left_drive;
        logic signed [SPEED_W-1:0] right_drive;
        logic signed [CORR_W-1:0]  correction;
        logic                      red_mark;
    } t_drive_word;

    // Every input of the block holds a known value from time zero.
    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_in_valid       = 1'b0;
    logic                      o_in_stall;
    logic [LEVEL_W-1:0]        i_reflect_sample = '0;
    logic                      o_out_valid;
    logic                      i_out_stall      = 1'b0;
    logic signed [SPEED_W-1:0] o_left_drive;
    logic signed [SPEED_W-1:0] o_right_drive;
    logic signed [CORR_W-1:0]  o_correction;
    logic                      o_red_mark;
    logic                      i_cfg_valid      = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data       = '0;

    // Our own copy of the register file and of the loop state. Both start
    // at the values the block takes on reset.
    lfpd_pkg::t_cfg settings = '{
        target_level: lfpd_pkg::RST_TARGET_LEVEL,
        prop_gain:    lfpd_pkg::RST_PROP_GAIN,
        integ_gain:   lfpd_pkg::RST_INTEG_GAIN,
        deriv_gain:   lfpd_pkg::RST_DERIV_GAIN,
        base_speed:   lfpd_pkg::RST_BASE_SPEED,
        mark_low:     lfpd_pkg::RST_MARK_LOW,
        mark_high:    lfpd_pkg::RST_MARK_HIGH
    };
    logic signed [SUM_WIDTH-1:0] error_integral = '0;
    logic signed [ERR_W-1:0]     model_prev_err = '0;

    // Samples waiting to be sent, and the result words still owed by the block.
    logic [LEVEL_W-1:0] pending_samples[$];
    t_drive_word        owed_words[$];

    // Idling knobs, changed only while the pipeline is empty.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fault_count   = 0;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    line_follow_pid_drive DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_reflect_sample (i_reflect_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_drive     (o_left_drive),
        .o_right_drive    (o_right_drive),
        .o_correction     (o_correction),
        .o_red_mark       (o_red_mark),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Steering model
    // ------------------------------------------------------------------------

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Register writes keep only the bits that the register holds; the
    // unmapped index falls through and changes nothing.
    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            lfpd_pkg::REG_TARGET_LEVEL: settings.target_level = data[LEVEL_W-1:0];
            lfpd_pkg::REG_PROP_GAIN:    settings.prop_gain    = data[GAIN_W-1:0];
            lfpd_pkg::REG_INTEG_GAIN:   settings.integ_gain   = data[GAIN_W-1:0];
            lfpd_pkg::REG_DERIV_GAIN:   settings.deriv_gain   = data[GAIN_W-1:0];
            lfpd_pkg::REG_BASE_SPEED:   settings.base_speed   = data[SPEED_W-1:0];
            lfpd_pkg::REG_MARK_LOW:     settings.mark_low     = data[LEVEL_W-1:0];
            lfpd_pkg::REG_MARK_HIGH:    settings.mark_high    = data[LEVEL_W-1:0];
            default: ;
        endcase
    endfunction

    // Runs one sample through the PID law and the differential mix, and
    // advances the integral and the remembered error exactly once.
    function automatic t_drive_word steer(input logic [LEVEL_W-1:0] sample);
        longint      err;
        longint      integ;
        longint      deriv;
        longint      acc;
        longint      corr;
        longint      base;
        t_drive_word w;
        err   = longint'(settings.target_level) - longint'(sample);
        integ = clip(longint'(error_integral) + err, INTEG_MIN, INTEG_MAX);
        deriv = err - longint'(model_prev_err);
        acc   = longint'(settings.prop_gain) * err
              + longint'(settings.integ_gain) * integ
              + longint'(settings.deriv_gain) * deriv;
        // An arithmetic shift of a signed value is a floor division.
        corr  = clip(acc >>> GAIN_FRAC_BITS, CORR_MIN, CORR_MAX);
        base  = longint'($signed(settings.base_speed));
        error_integral = SUM_WIDTH'(integ);
        model_prev_err = ERR_W'(err);
        w.left_drive  = SPEED_W'(clip(base - corr, lfpd_pkg::DRIVE_MIN, lfpd_pkg::DRIVE_MAX));
        w.right_drive = SPEED_W'(clip(base + corr, lfpd_pkg::DRIVE_MIN, lfpd_pkg::DRIVE_MAX));
        w.correction  = CORR_W'(corr);
        w.red_mark    = (sample >= settings.mark_low) && (sample <= settings.mark_high);
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver: pops the pending queue, holds a stalled word steady,
    // and predicts each word at the edge where it is taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall)
            owed_words.push_back(steer(i_reflect_sample));
        // The channel is free when nothing is offered or the offer was just
        // taken. Valid is set exactly once per edge, so back-to-back words
        // keep it high without a glitch.
        if (!i_in_valid || !o_in_stall) begin
            if (i_rst_n && pending_samples.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                i_reflect_sample <= pending_samples.pop_front();
                i_in_valid       <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks each accepted word against the oldest owed
    // one, and throws random back-pressure at the output.
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string field,
                                          input logic signed [CORR_W-1:0] want,
                                          input logic signed [CORR_W-1:0] got);
        if (got !== want) begin
            fault_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_drive_word want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (owed_words.size() == 0) begin
                fault_count++;
                $display("%0t ns: unexpected result word, expected none, got %0d %0d %0d %0b",
                         $time, o_left_drive, o_right_drive, o_correction, o_red_mark);
            end else begin
                want = owed_words.pop_front();
                compare_field("left_drive",  want.left_drive,  o_left_drive);
                compare_field("right_drive", want.right_drive, o_right_drive);
                compare_field("correction",  want.correction,  o_correction);
                compare_field("red_mark",    want.red_mark,    o_red_mark);
            end
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        apply_setting(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // Writes all seven registers. Narrow registers get random junk above
    // their width, which the block has to drop.
    task automatic load_settings(input lfpd_pkg::t_cfg s);
        write_setting(lfpd_pkg::REG_TARGET_LEVEL, CFG_DATA_W'({$urandom, s.target_level}));
        write_setting(lfpd_pkg::REG_PROP_GAIN,    s.prop_gain);
        write_setting(lfpd_pkg::REG_INTEG_GAIN,   s.integ_gain);
        write_setting(lfpd_pkg::REG_DERIV_GAIN,   s.deriv_gain);
        write_setting(lfpd_pkg::REG_BASE_SPEED,   CFG_DATA_W'({$urandom, s.base_speed}));
        write_setting(lfpd_pkg::REG_MARK_LOW,     CFG_DATA_W'({$urandom, s.mark_low}));
        write_setting(lfpd_pkg::REG_MARK_HIGH,    CFG_DATA_W'({$urandom, s.mark_high}));
    endtask

    // The sender sits idle until every word it sent has come back.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || i_in_valid || owed_words.size() != 0)
            @(posedge i_clk);
    endtask

    // Gains: mostly below one, as a tuned loop would use, sometimes anywhere
    // in the Q2 range so the correction saturates.
    function automatic logic [GAIN_W-1:0] pick_gain();
        if ($urandom_range(3) == 0)
            return GAIN_W'($urandom);
        return GAIN_W'($urandom_range(1 << GAIN_FRAC_BITS));
    endfunction

    function automatic lfpd_pkg::t_cfg random_settings();
        lfpd_pkg::t_cfg s;
        s.target_level = ($urandom_range(3) == 0) ? LEVEL_W'($urandom)
                                                  : LEVEL_W'($urandom_range(100));
        s.prop_gain    = pick_gain();
        s.integ_gain   = pick_gain();
        s.deriv_gain   = pick_gain();
        s.base_speed   = ($urandom_range(3) == 0) ? SPEED_W'($urandom)
                                                  : SPEED_W'($urandom_range(200) - 100);
        s.mark_low     = LEVEL_W'($urandom_range(100));
        s.mark_high    = LEVEL_W'($urandom_range(100));
        return s;
    endfunction

    // A sensor tracking a line drifts a little from one reading to the
    // next; now and then a reading jumps anywhere in the 7-bit range.
    function automatic void queue_readings(input int count);
        int level;
        level = int'(clip(longint'(settings.target_level), 0, 100));
        repeat (count) begin
            if ($urandom_range(9) < 7)
                level = int'(clip(level + int'($urandom_range(10)) - 5, 0, 100));
            else
                level = int'($urandom_range(127));
            pending_samples.push_back(LEVEL_W'(level));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        lfpd_pkg::t_cfg s;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero error, both range ends, a reading above 100,
        // and readings on and just outside each edge of the red band.
        pending_samples = '{7'd40, 7'd0, 7'd100, 7'd127, 7'd64, 7'd65, 7'd75,
                            7'd76, 7'd40};
        wait_drained();

        // Set point above 100, every gain at its top, base speed above the
        // drive limit, and an empty red band. A write to the unmapped index
        // must not disturb anything.
        s = '{target_level: 7'd127, prop_gain: '1, integ_gain: '1, deriv_gain: '1,
              base_speed: 8'sd127, mark_low: 7'd100, mark_high: 7'd0};
        load_settings(s);
        write_setting(REG_UNMAPPED, '1);
        pending_samples = '{7'd0, 7'd127, 7'd0, 7'd100};
        wait_drained();

        // Most negative base speed with zero gains: both drives pin at the
        // low limit. The band covers every possible reading.
        s = '{target_level: 7'd0, prop_gain: '0, integ_gain: '0, deriv_gain: '0,
              base_speed: 8'h80, mark_low: 7'd0, mark_high: 7'd127};
        load_settings(s);
        pending_samples = '{7'd0, 7'd127, 7'd64};
        wait_drained();

        // Tuned gains at the bottom of the drive range, single-value band.
        s = '{target_level: 7'd100, prop_gain: lfpd_pkg::RST_PROP_GAIN,
              integ_gain: lfpd_pkg::RST_INTEG_GAIN, deriv_gain: lfpd_pkg::RST_DERIV_GAIN,
              base_speed: -8'sd100, mark_low: 7'd0, mark_high: 7'd0};
        load_settings(s);
        pending_samples = '{7'd0, 7'd1, 7'd100, 7'd50};
        wait_drained();

        // Random part: four idling patterns, each with fresh settings. Every
        // phase is sent in two halves with a full drain in between.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 80; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            load_settings(random_settings());
            queue_readings(130);
            wait_drained();
            load_settings(random_settings());
            queue_readings(130);
            wait_drained();
        end
        send_idle_pct = 0;
        stall_pct     = 0;

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
src/lfpd_pkg.sv
src/lfpd_cfg_regs.sv
src/line_follow_pid_drive.sv
tb/tb.sv
